// ===== rtl/core/vector3_alu_top_defines.svh =====
// Assertion macros for the vector ALU top level.
// Stands alone; the including file supplies clock, reset and signal names.
`ifndef VECTOR3_ALU_TOP_DEFINES_SVH
`define VECTOR3_ALU_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define V3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define V3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/v3alu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the vector ALU.
// No dependencies; used by the lane, merge and top-level modules.
package v3alu_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int WORD_BITS  = 32;
	localparam int FUNC_BITS  = 4;
	localparam int TOL_BITS   = WORD_BITS - 1;
	localparam int LIN_BITS   = WORD_BITS + 1;
	localparam int PROD_BITS  = 2 * WORD_BITS;
	localparam int LANE_BITS  = PROD_BITS + 1;
	localparam int SUM_BITS   = PROD_BITS + 2;
	localparam int SH_BITS    = SUM_BITS - FRAC_BITS;
	localparam int LANES      = 3;
	localparam int COMPS      = 4;

	localparam int S_DATA_BITS = ((9 * WORD_BITS + TOL_BITS + 7) / 8) * 8;
	localparam int S_USER_BITS = ((FUNC_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS = ((4 * WORD_BITS + 7) / 8) * 8;
	localparam int M_USER_BITS = 8;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [LIN_BITS-1:0]  lin_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [LANE_BITS-1:0] lane_acc_t;
	typedef logic signed [SUM_BITS-1:0]  sum_t;
	typedef logic [TOL_BITS-1:0]         tol_t;

	localparam word_t WMAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
	localparam word_t WMIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
	localparam word_t ONE  = word_t'(1 << FRAC_BITS);

	typedef enum logic [FUNC_BITS-1:0] {
		FN_ADD       = 4'd0,
		FN_SUB       = 4'd1,
		FN_SCALE     = 4'd2,
		FN_NEGATE    = 4'd3,
		FN_DOT       = 4'd4,
		FN_CROSS     = 4'd5,
		FN_MAGSQR    = 4'd6,
		FN_EQUAL_TOL = 4'd7,
		FN_ZERO_TOL  = 4'd8
	} func_t;

	// What kind of result an item produces, decided at the first stage.
	typedef enum logic [2:0] {
		KD_NONE,
		KD_LIN,
		KD_PROD,
		KD_SUM,
		KD_CMP
	} kind_t;

	// Operands of one lane: the lane forms m0a*m0b +/- m1a*m1b.
	typedef struct packed {
		word_t m0a;
		word_t m0b;
		word_t m1a;
		word_t m1b;
		logic  psub;
	} lane_op_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	typedef struct packed {
		kind_t kind;
		word_t lin_x;
		word_t lin_y;
		word_t lin_z;
		logic  lin_sat;
		logic  flag;
	} merge_in_t;

	typedef struct packed {
		word_t rx;
		word_t ry;
		word_t rz;
		word_t rw;
		logic  flag;
		logic  sat;
	} result_t;

	typedef struct packed {
		word_t val;
		logic  sat;
	} fin_t;

	// Arithmetic shift right by FRAC_BITS, then saturate to a word.
	function automatic fin_t finish(input sum_t v);
		logic signed [SH_BITS-1:0] sh;
		fin_t r;
		sh = v[SUM_BITS-1:FRAC_BITS];
		if (sh[SH_BITS-1:WORD_BITS-1] == {(SH_BITS-WORD_BITS+1){sh[SH_BITS-1]}}) begin
			r.val = sh[WORD_BITS-1:0];
			r.sat = 1'b0;
		end else begin
			r.val = sh[SH_BITS-1] ? WMIN : WMAX;
			r.sat = 1'b1;
		end
		return r;
	endfunction

	// Saturate a one-bit-grown sum or difference to a word.
	function automatic fin_t clip(input lin_t v);
		fin_t r;
		if (v[LIN_BITS-1] == v[LIN_BITS-2]) begin
			r.val = v[WORD_BITS-1:0];
			r.sat = 1'b0;
		end else begin
			r.val = v[LIN_BITS-1] ? WMIN : WMAX;
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/v3alu_lane.sv =====
// One multiply lane: two word products, then their sum or difference.
// Depends on v3alu_pkg.
module v3alu_lane (
	input  logic                  clk,
	input  v3alu_pkg::stage_en_t  en,
	input  v3alu_pkg::lane_op_t   op,
	output v3alu_pkg::lane_acc_t  acc_s3
);

	v3alu_pkg::prod_t prod0_s2;
	v3alu_pkg::prod_t prod1_s2;
	logic             psub_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod0_s2 <= op.m0a * op.m0b;
			prod1_s2 <= op.m1a * op.m1b;
			psub_s2  <= op.psub;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (psub_s2) begin
				acc_s3 <= v3alu_pkg::LANE_BITS'(prod0_s2) - v3alu_pkg::LANE_BITS'(prod1_s2);
			end else begin
				acc_s3 <= v3alu_pkg::LANE_BITS'(prod0_s2) + v3alu_pkg::LANE_BITS'(prod1_s2);
			end
		end
	end

endmodule

// ===== rtl/core/v3alu_merge.sv =====
// Merge stage: combines lane results, shifts and saturates, and holds the output register.
// Depends on v3alu_pkg.
module v3alu_merge (
	input  logic                  clk,
	input  logic                  en,
	input  v3alu_pkg::merge_in_t  ctl,
	input  v3alu_pkg::lane_acc_t  acc [v3alu_pkg::LANES],
	output v3alu_pkg::result_t    res_s4
);

	v3alu_pkg::sum_t    dot_sum;
	v3alu_pkg::fin_t    fin_sum;
	v3alu_pkg::fin_t    fin_lane [v3alu_pkg::LANES];
	v3alu_pkg::result_t res_d;

	always_comb begin
		// Dot and squared magnitude spread their three products over two lanes.
		dot_sum = v3alu_pkg::SUM_BITS'(acc[0]) + v3alu_pkg::SUM_BITS'(acc[1]);
		fin_sum = v3alu_pkg::finish(dot_sum);
		for (int i = 0; i < v3alu_pkg::LANES; i++) begin
			fin_lane[i] = v3alu_pkg::finish(v3alu_pkg::SUM_BITS'(acc[i]));
		end
		res_d = '0;
		unique case (ctl.kind)
			v3alu_pkg::KD_LIN: begin
				res_d.rx  = ctl.lin_x;
				res_d.ry  = ctl.lin_y;
				res_d.rz  = ctl.lin_z;
				res_d.rw  = v3alu_pkg::ONE;
				res_d.sat = ctl.lin_sat;
			end
			v3alu_pkg::KD_PROD: begin
				res_d.rx  = fin_lane[0].val;
				res_d.ry  = fin_lane[1].val;
				res_d.rz  = fin_lane[2].val;
				res_d.rw  = v3alu_pkg::ONE;
				res_d.sat = fin_lane[0].sat | fin_lane[1].sat | fin_lane[2].sat;
			end
			v3alu_pkg::KD_SUM: begin
				res_d.rx  = fin_sum.val;
				res_d.sat = fin_sum.sat;
			end
			v3alu_pkg::KD_CMP: begin
				res_d.flag = ctl.flag;
			end
			v3alu_pkg::KD_NONE: begin
				res_d = '0;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res_d;
		end
	end

endmodule

// ===== rtl/core/vector3_alu_top.sv =====
// Top level of the homogeneous 3D vector ALU in signed Q16.16 fixed point.
// Depends on v3alu_pkg, v3alu_lane, v3alu_merge and vector3_alu_top_defines.svh.
//
// Channel   Direction  Signals                       Contents
// s_*       in         s_tvalid s_tready s_tdata      operands, tuser = operation code
//                      s_tuser
// m_*       out        m_tvalid m_tready m_tdata      result vector, tuser = flag, saturated
//                      m_tuser
//
// Every item passes four register stages, and one item may enter every clock cycle
// as long as the output takes its results. The depth is set by the operand select stage,
// the lane multipliers, the lane add/subtract and the merge stage with its saturation.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled output holds its stage and backs up the stages behind it one at a time,
// so bubbles are squeezed out and input transfers continue until the pipe is full.

`include "vector3_alu_top_defines.svh"

module vector3_alu_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// From bit 0 up: ax, ay, az, aw, bx, by, bz, bw, scale_factor, tolerance, zero pad.
	input  logic [v3alu_pkg::S_DATA_BITS-1:0]   s_tdata,
	// From bit 0 up: func, zero pad.
	input  logic [v3alu_pkg::S_USER_BITS-1:0]   s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// From bit 0 up: rx, ry, rz, rw.
	output logic [v3alu_pkg::M_DATA_BITS-1:0]   m_tdata,
	// From bit 0 up: flag, saturated, zero pad.
	output logic [v3alu_pkg::M_USER_BITS-1:0]   m_tuser
);

	localparam int W = v3alu_pkg::WORD_BITS;

	// Stage handshake: a stage loads whenever it is empty or its successor loads.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic load_s1, load_s2, load_s3, load_s4;

	assign load_s4  = !valid_s4 || m_tready;
	assign load_s3  = !valid_s3 || load_s4;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign s_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= s_tvalid;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
		end
	end

	// Field extraction from the input transfer.
	v3alu_pkg::word_t a_in [v3alu_pkg::COMPS];
	v3alu_pkg::word_t b_in [v3alu_pkg::COMPS];
	v3alu_pkg::word_t scl_in;
	v3alu_pkg::tol_t  tol_in;
	v3alu_pkg::func_t fn;

	always_comb begin
		for (int i = 0; i < v3alu_pkg::COMPS; i++) begin
			a_in[i] = s_tdata[i*W +: W];
			b_in[i] = s_tdata[(i+v3alu_pkg::COMPS)*W +: W];
		end
		scl_in = s_tdata[8*W +: W];
		tol_in = s_tdata[9*W +: v3alu_pkg::TOL_BITS];
		fn     = v3alu_pkg::func_t'(s_tuser[v3alu_pkg::FUNC_BITS-1:0]);
	end

	// Stage 1: decode the operation, route operands to the lanes, and form the
	// one-bit-grown sums and compare differences.
	v3alu_pkg::kind_t    kind_d;
	v3alu_pkg::lane_op_t lane_op_d [v3alu_pkg::LANES];
	v3alu_pkg::lin_t     lin_d     [v3alu_pkg::LANES];
	v3alu_pkg::lin_t     diff_d    [v3alu_pkg::COMPS];

	always_comb begin
		kind_d = v3alu_pkg::KD_NONE;
		for (int i = 0; i < v3alu_pkg::LANES; i++) begin
			lane_op_d[i] = '0;
			lin_d[i]     = '0;
		end
		for (int i = 0; i < v3alu_pkg::COMPS; i++) begin
			diff_d[i] = '0;
		end
		unique case (fn)
			v3alu_pkg::FN_ADD: begin
				kind_d = v3alu_pkg::KD_LIN;
				for (int i = 0; i < v3alu_pkg::LANES; i++) begin
					lin_d[i] = v3alu_pkg::LIN_BITS'(a_in[i]) + v3alu_pkg::LIN_BITS'(b_in[i]);
				end
			end
			v3alu_pkg::FN_SUB: begin
				kind_d = v3alu_pkg::KD_LIN;
				for (int i = 0; i < v3alu_pkg::LANES; i++) begin
					lin_d[i] = v3alu_pkg::LIN_BITS'(a_in[i]) - v3alu_pkg::LIN_BITS'(b_in[i]);
				end
			end
			v3alu_pkg::FN_NEGATE: begin
				kind_d = v3alu_pkg::KD_LIN;
				for (int i = 0; i < v3alu_pkg::LANES; i++) begin
					lin_d[i] = -v3alu_pkg::LIN_BITS'(a_in[i]);
				end
			end
			v3alu_pkg::FN_SCALE: begin
				kind_d = v3alu_pkg::KD_PROD;
				for (int i = 0; i < v3alu_pkg::LANES; i++) begin
					lane_op_d[i].m0a = a_in[i];
					lane_op_d[i].m0b = scl_in;
				end
			end
			v3alu_pkg::FN_CROSS: begin
				kind_d = v3alu_pkg::KD_PROD;
				lane_op_d[0] = '{m0a: a_in[1], m0b: b_in[2], m1a: a_in[2], m1b: b_in[1],
					psub: 1'b1};
				lane_op_d[1] = '{m0a: a_in[2], m0b: b_in[0], m1a: a_in[0], m1b: b_in[2],
					psub: 1'b1};
				lane_op_d[2] = '{m0a: a_in[0], m0b: b_in[1], m1a: a_in[1], m1b: b_in[0],
					psub: 1'b1};
			end
			v3alu_pkg::FN_DOT: begin
				// x and y products share lane 0, z goes to lane 1.
				kind_d = v3alu_pkg::KD_SUM;
				lane_op_d[0] = '{m0a: a_in[0], m0b: b_in[0], m1a: a_in[1], m1b: b_in[1],
					psub: 1'b0};
				lane_op_d[1].m0a = a_in[2];
				lane_op_d[1].m0b = b_in[2];
			end
			v3alu_pkg::FN_MAGSQR: begin
				kind_d = v3alu_pkg::KD_SUM;
				lane_op_d[0] = '{m0a: a_in[0], m0b: a_in[0], m1a: a_in[1], m1b: a_in[1],
					psub: 1'b0};
				lane_op_d[1].m0a = a_in[2];
				lane_op_d[1].m0b = a_in[2];
			end
			v3alu_pkg::FN_EQUAL_TOL: begin
				kind_d = v3alu_pkg::KD_CMP;
				for (int i = 0; i < v3alu_pkg::COMPS; i++) begin
					diff_d[i] = v3alu_pkg::LIN_BITS'(a_in[i]) - v3alu_pkg::LIN_BITS'(b_in[i]);
				end
			end
			v3alu_pkg::FN_ZERO_TOL: begin
				// The target is the origin point, whose w is one.
				kind_d = v3alu_pkg::KD_CMP;
				for (int i = 0; i < v3alu_pkg::LANES; i++) begin
					diff_d[i] = v3alu_pkg::LIN_BITS'(a_in[i]);
				end
				diff_d[3] = v3alu_pkg::LIN_BITS'(a_in[3]) - v3alu_pkg::LIN_BITS'(v3alu_pkg::ONE);
			end
			default: begin
				kind_d = v3alu_pkg::KD_NONE;
			end
		endcase
	end

	v3alu_pkg::kind_t    kind_s1;
	v3alu_pkg::lane_op_t lane_op_s1 [v3alu_pkg::LANES];
	v3alu_pkg::lin_t     lin_s1     [v3alu_pkg::LANES];
	v3alu_pkg::lin_t     diff_s1    [v3alu_pkg::COMPS];
	v3alu_pkg::tol_t     tol_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1    <= kind_d;
			lane_op_s1 <= lane_op_d;
			lin_s1     <= lin_d;
			diff_s1    <= diff_d;
			tol_s1     <= tol_in;
		end
	end

	// Stage 2: saturate the sums and test each difference against the tolerance.
	v3alu_pkg::fin_t        lin_fin [v3alu_pkg::LANES];
	logic [v3alu_pkg::LIN_BITS-1:0] diff_mag [v3alu_pkg::COMPS];
	logic [v3alu_pkg::COMPS-1:0]    in_tol;

	always_comb begin
		for (int i = 0; i < v3alu_pkg::LANES; i++) begin
			lin_fin[i] = v3alu_pkg::clip(lin_s1[i]);
		end
		for (int i = 0; i < v3alu_pkg::COMPS; i++) begin
			diff_mag[i] = diff_s1[i][v3alu_pkg::LIN_BITS-1] ? -diff_s1[i] : diff_s1[i];
			in_tol[i]   = diff_mag[i] <= v3alu_pkg::LIN_BITS'(tol_s1);
		end
	end

	v3alu_pkg::kind_t kind_s2, kind_s3;
	v3alu_pkg::word_t lin_s2 [v3alu_pkg::LANES];
	v3alu_pkg::word_t lin_s3 [v3alu_pkg::LANES];
	logic             lin_sat_s2, lin_sat_s3;
	logic             flag_s2, flag_s3;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			kind_s2    <= kind_s1;
			for (int i = 0; i < v3alu_pkg::LANES; i++) begin
				lin_s2[i] <= lin_fin[i].val;
			end
			lin_sat_s2 <= lin_fin[0].sat | lin_fin[1].sat | lin_fin[2].sat;
			flag_s2    <= (kind_s1 == v3alu_pkg::KD_CMP) && (&in_tol);
		end
	end

	// Stage 3: side-band results wait while the lanes finish their products.
	always_ff @(posedge clk) begin
		if (load_s3) begin
			kind_s3    <= kind_s2;
			lin_s3     <= lin_s2;
			lin_sat_s3 <= lin_sat_s2;
			flag_s3    <= flag_s2;
		end
	end

	// Multiply lanes, one per vector component.
	v3alu_pkg::stage_en_t lane_en;
	v3alu_pkg::lane_acc_t lane_acc [v3alu_pkg::LANES];

	assign lane_en = '{s2: load_s2, s3: load_s3};

	for (genvar g = 0; g < v3alu_pkg::LANES; g++) begin : g_lane
		v3alu_lane u_lane (
			.clk    (clk),
			.en     (lane_en),
			.op     (lane_op_s1[g]),
			.acc_s3 (lane_acc[g])
		);
	end

	// Stage 4: merge the lanes into the output register.
	v3alu_pkg::merge_in_t merge_ctl;
	v3alu_pkg::result_t   res_s4;

	assign merge_ctl = '{kind: kind_s3, lin_x: lin_s3[0], lin_y: lin_s3[1], lin_z: lin_s3[2],
		lin_sat: lin_sat_s3, flag: flag_s3};

	v3alu_merge u_merge (
		.clk    (clk),
		.en     (load_s4),
		.ctl    (merge_ctl),
		.acc    (lane_acc),
		.res_s4 (res_s4)
	);

	assign m_tvalid = valid_s4;
	assign m_tdata  = {res_s4.rw, res_s4.rz, res_s4.ry, res_s4.rx};
	assign m_tuser  = {{(v3alu_pkg::M_USER_BITS-2){1'b0}}, res_s4.sat, res_s4.flag};

	// A compare result carries no vector components.
	`V3_ASSERT_NOW(a_cmp_zero_vec, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0,
		"compare result with nonzero components")

	// A result never reports both a held compare and a clipped component.
	`V3_ASSERT_NOW(a_flag_no_sat, clk, arst_n, m_tvalid && m_tuser[1], !m_tuser[0],
		"saturated result also flags a compare")

	// An input transfer always occupies the first stage on the next cycle.
	`V3_ASSERT_NEXT(a_s1_fill, clk, arst_n, s_tvalid && s_tready, valid_s1,
		"accepted transfer lost before stage 1")

	// With every stage full and the output stalled, no transfer may enter.
	`V3_ASSERT_NOW(a_full_stall, clk, arst_n,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_tready, !s_tready,
		"input accepted into a full, stalled pipeline")

endmodule

// ===== verif/tb_vector3_alu_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for vector3_alu_top: directed corner rows, then random operations.
// Depends on v3alu_pkg and the vector3_alu_top RTL; expected results come from an in-bench model or are typed in.

module tb_vector3_alu_top;
	import v3alu_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 550;
	localparam int MAX_GAP      = 12;
	// The result sink holds off once, after this many results, for this many cycles.
	localparam int HOLD_AT      = 180;
	localparam int HOLD_CYCLES  = 80;
	// The operand source sends back to back while this window of transfers is open.
	localparam int BURST_FIRST  = 170;
	localparam int BURST_LAST   = 270;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;

	// Operation codes the block does not define; they must give an all-zero result.
	localparam logic [FUNC_BITS-1:0] FN_SPARE_LO = 4'd9;
	localparam logic [FUNC_BITS-1:0] FN_SPARE_HI = 4'd15;
	localparam tol_t TOL_MAX = '1;

	// Wide enough to hold any sum of three exact products without loss.
	typedef logic signed [127:0] big_t;

	typedef struct packed {
		logic [FUNC_BITS-1:0] func;
		word_t ax, ay, az, aw;
		word_t bx, by, bz, bw;
		word_t scale;
		tol_t  tol;
	} vec_op_t;

	typedef struct packed {
		word_t rx, ry, rz, rw;
		logic  flag;
		logic  sat;
	} vec_res_t;

	// One directed row: the operation, and the result typed in where it is obvious.
	typedef struct packed {
		vec_op_t  op;
		logic     typed;
		vec_res_t want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_DATA_BITS-1:0] s_tdata;
	logic [S_USER_BITS-1:0] s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_DATA_BITS-1:0] m_tdata;
	logic [M_USER_BITS-1:0] m_tuser;

	// Results still owed by the block, oldest first.
	vec_res_t  awaited_results[$];
	stim_row_t corner_rows[$];
	int        mismatch_count = 0;
	int        results_seen   = 0;
	int        items_sent     = 0;

	vector3_alu_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Result model. All arithmetic is done exactly in 128 bits, so the only
	// places where bits are lost are the explicit shift and the clamp.
	// ------------------------------------------------------------------

	function automatic big_t ext(input word_t x);
		big_t r;
		r = x;
		return r;
	endfunction

	function automatic big_t wide_mul(input word_t x, input word_t y);
		return ext(x) * ext(y);
	endfunction

	// Clamp an exact value to the signed word, noting any clipping.
	function automatic word_t clamp_word(input big_t v, inout logic sat);
		if (v > ext(WMAX)) begin
			sat = 1'b1;
			return WMAX;
		end
		if (v < ext(WMIN)) begin
			sat = 1'b1;
			return WMIN;
		end
		return v[WORD_BITS-1:0];
	endfunction

	// Drop the fraction of a product sum (toward minus infinity), then clamp.
	function automatic word_t shift_clamp(input big_t v, inout logic sat);
		return clamp_word(v >>> FRAC_BITS, sat);
	endfunction

	function automatic logic within_tol(input big_t d, input tol_t tol);
		big_t lim;
		lim = {97'b0, tol};
		if (d < 0)
			d = -d;
		return d <= lim;
	endfunction

	function automatic vec_res_t compute_vector_op(input vec_op_t op);
		vec_res_t r;
		logic     sat;
		r   = '0;
		sat = 1'b0;
		case (op.func)
			FN_ADD: begin
				r.rx = clamp_word(ext(op.ax) + ext(op.bx), sat);
				r.ry = clamp_word(ext(op.ay) + ext(op.by), sat);
				r.rz = clamp_word(ext(op.az) + ext(op.bz), sat);
				r.rw = ONE;
			end
			FN_SUB: begin
				r.rx = clamp_word(ext(op.ax) - ext(op.bx), sat);
				r.ry = clamp_word(ext(op.ay) - ext(op.by), sat);
				r.rz = clamp_word(ext(op.az) - ext(op.bz), sat);
				r.rw = ONE;
			end
			FN_SCALE: begin
				r.rx = shift_clamp(wide_mul(op.ax, op.scale), sat);
				r.ry = shift_clamp(wide_mul(op.ay, op.scale), sat);
				r.rz = shift_clamp(wide_mul(op.az, op.scale), sat);
				r.rw = ONE;
			end
			FN_NEGATE: begin
				r.rx = clamp_word(-ext(op.ax), sat);
				r.ry = clamp_word(-ext(op.ay), sat);
				r.rz = clamp_word(-ext(op.az), sat);
				r.rw = ONE;
			end
			FN_DOT: begin
				r.rx = shift_clamp(wide_mul(op.ax, op.bx) + wide_mul(op.ay, op.by)
					+ wide_mul(op.az, op.bz), sat);
			end
			FN_CROSS: begin
				r.rx = shift_clamp(wide_mul(op.ay, op.bz) - wide_mul(op.az, op.by), sat);
				r.ry = shift_clamp(wide_mul(op.az, op.bx) - wide_mul(op.ax, op.bz), sat);
				r.rz = shift_clamp(wide_mul(op.ax, op.by) - wide_mul(op.ay, op.bx), sat);
				r.rw = ONE;
			end
			FN_MAGSQR: begin
				r.rx = shift_clamp(wide_mul(op.ax, op.ax) + wide_mul(op.ay, op.ay)
					+ wide_mul(op.az, op.az), sat);
			end
			FN_EQUAL_TOL: begin
				r.flag = within_tol(ext(op.ax) - ext(op.bx), op.tol)
					&& within_tol(ext(op.ay) - ext(op.by), op.tol)
					&& within_tol(ext(op.az) - ext(op.bz), op.tol)
					&& within_tol(ext(op.aw) - ext(op.bw), op.tol);
			end
			FN_ZERO_TOL: begin
				// The reference point is the homogeneous origin, so w is held against 1.0.
				r.flag = within_tol(ext(op.ax), op.tol) && within_tol(ext(op.ay), op.tol)
					&& within_tol(ext(op.az), op.tol)
					&& within_tol(ext(op.aw) - ext(ONE), op.tol);
			end
			default: begin
			end
		endcase
		r.sat = sat;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------

	function automatic vec_op_t mk_op(input logic [FUNC_BITS-1:0] func,
			input word_t ax, input word_t ay, input word_t az, input word_t aw,
			input word_t bx, input word_t by, input word_t bz, input word_t bw,
			input word_t scale, input tol_t tol);
		vec_op_t op;
		op.func  = func;
		op.ax    = ax;
		op.ay    = ay;
		op.az    = az;
		op.aw    = aw;
		op.bx    = bx;
		op.by    = by;
		op.bz    = bz;
		op.bw    = bw;
		op.scale = scale;
		op.tol   = tol;
		return op;
	endfunction

	function automatic vec_res_t mk_res(input word_t rx, input word_t ry, input word_t rz,
			input word_t rw, input logic flag, input logic sat);
		vec_res_t r;
		r.rx   = rx;
		r.ry   = ry;
		r.rz   = rz;
		r.rw   = rw;
		r.flag = flag;
		r.sat  = sat;
		return r;
	endfunction

	task automatic add_row(input vec_op_t op, input logic typed, input vec_res_t want);
		stim_row_t row;
		row.op    = op;
		row.typed = typed;
		row.want  = want;
		corner_rows.push_back(row);
	endtask

	// Operand values: full range in four draws of ten, with a good share of small values (so that
	// products stay in range) and of the rails.
	function automatic word_t pick_word();
		word_t w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: w = $urandom;
			4, 5, 6:    w = $urandom_range(0, 8 * ONE) - 4 * ONE;
			7:          w = WMAX;
			8:          w = WMIN;
			default: begin
				case ($urandom_range(0, 4))
					0:       w = '0;
					1:       w = 1;
					2:       w = -1;
					3:       w = ONE;
					default: w = -ONE;
				endcase
			end
		endcase
		return w;
	endfunction

	// A small signed offset, used to build vectors close to a reference.
	function automatic word_t jitter();
		word_t j;
		j = $urandom_range(0, 512);
		return j - 256;
	endfunction

	// Presents one operand transfer, waits for it to be taken, then records the
	// expected result. Gaps after the transfer are drawn per item, except in
	// stretches where the source runs back to back.
	task automatic drive_item(input vec_op_t op, input vec_res_t want);
		int   gap;
		logic burst;
		s_tdata  <= {op.tol, op.scale, op.bw, op.bz, op.by, op.bx, op.aw, op.az, op.ay, op.ax};
		s_tuser  <= op.func;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		awaited_results.push_back(want);
		items_sent++;
		burst = ((items_sent / 40) % 3 == 2)
			|| (items_sent >= BURST_FIRST && items_sent < BURST_LAST);
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Operand source: reset, the directed corner rows, then random items.
	// ------------------------------------------------------------------
	initial begin : operand_source
		vec_op_t  op;
		vec_res_t none;
		logic     near;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		none = '0;

		// Sums and differences run into both rails while z stays in range.
		add_row(mk_op(FN_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, ONE, 1'b0, 1'b0));
		add_row(mk_op(FN_ADD, WMAX, WMIN, 1, 0, WMAX, WMIN, 2, 0, 0, 0), 1'b1,
			mk_res(WMAX, WMIN, 3, ONE, 1'b0, 1'b1));
		add_row(mk_op(FN_SUB, WMIN, WMAX, 5, 0, 1, -1, 3, 0, 0, 0), 1'b1,
			mk_res(WMIN, WMAX, 2, ONE, 1'b0, 1'b1));
		// Scaling by 3.0, and scaling at the rails.
		add_row(mk_op(FN_SCALE, ONE, 2 * ONE, -ONE, 0, 0, 0, 0, 0, 3 * ONE, 0), 1'b1,
			mk_res(3 * ONE, 6 * ONE, -3 * ONE, ONE, 1'b0, 1'b0));
		add_row(mk_op(FN_SCALE, WMAX, WMIN, ONE, 5, 0, 0, 0, 0, WMIN, 0), 1'b0, none);
		// Negating the most negative word is the one negate that clips.
		add_row(mk_op(FN_NEGATE, WMIN, WMAX, 0, 7, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(WMAX, -WMAX, 0, ONE, 1'b0, 1'b1));
		add_row(mk_op(FN_DOT, ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE, ONE, ONE, 0, 0), 1'b1,
			mk_res(6 * ONE, 0, 0, 0, 1'b0, 1'b0));
		add_row(mk_op(FN_DOT, WMIN, WMIN, WMIN, 0, WMIN, WMIN, WMIN, 0, 0, 0), 1'b1,
			mk_res(WMAX, 0, 0, 0, 1'b0, 1'b1));
		// A tiny negative product rounds down to -1 LSB, not toward zero.
		add_row(mk_op(FN_DOT, -1, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1,
			mk_res(-1, 0, 0, 0, 1'b0, 1'b0));
		add_row(mk_op(FN_DOT, WMAX, WMIN, ONE, 3, WMIN, WMIN, -ONE, 4, 0, 0), 1'b0, none);
		// x cross y gives z.
		add_row(mk_op(FN_CROSS, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, ONE, ONE, 1'b0, 1'b0));
		add_row(mk_op(FN_CROSS, WMAX, WMIN, WMAX, 0, WMIN, WMAX, WMIN, 0, 0, 0), 1'b0, none);
		add_row(mk_op(FN_MAGSQR, 3 * ONE, 4 * ONE, 0, 9, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(25 * ONE, 0, 0, 0, 1'b0, 1'b0));
		add_row(mk_op(FN_MAGSQR, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(WMAX, 0, 0, 0, 1'b0, 1'b1));
		// Compares: exact match, a difference right at the tolerance and one LSB past
		// it, the widest difference, and a difference in w alone.
		add_row(mk_op(FN_EQUAL_TOL, ONE, -ONE, 7, WMIN, ONE, -ONE, 7, WMIN, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 1'b1, 1'b0));
		add_row(mk_op(FN_EQUAL_TOL, 100, 0, 0, ONE, 0, 0, 0, ONE, 0, 100), 1'b1,
			mk_res(0, 0, 0, 0, 1'b1, 1'b0));
		add_row(mk_op(FN_EQUAL_TOL, 100, 0, 0, ONE, 0, 0, 0, ONE, 0, 99), 1'b1,
			mk_res(0, 0, 0, 0, 1'b0, 1'b0));
		add_row(mk_op(FN_EQUAL_TOL, WMAX, 0, 0, 0, 0, 0, 0, 0, 0, TOL_MAX), 1'b1,
			mk_res(0, 0, 0, 0, 1'b1, 1'b0));
		add_row(mk_op(FN_EQUAL_TOL, WMAX, 0, 0, 0, WMIN, 0, 0, 0, 0, TOL_MAX), 1'b1,
			mk_res(0, 0, 0, 0, 1'b0, 1'b0));
		add_row(mk_op(FN_EQUAL_TOL, 0, 0, 0, ONE, 0, 0, 0, ONE + 1, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 1'b0, 1'b0));
		add_row(mk_op(FN_ZERO_TOL, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 1'b1, 1'b0));
		add_row(mk_op(FN_ZERO_TOL, 50, -50, 50, ONE + 50, 0, 0, 0, 0, 0, 50), 1'b1,
			mk_res(0, 0, 0, 0, 1'b1, 1'b0));
		add_row(mk_op(FN_ZERO_TOL, 0, 0, 0, WMIN, 0, 0, 0, 0, 0, TOL_MAX), 1'b1,
			mk_res(0, 0, 0, 0, 1'b0, 1'b0));
		// Undefined codes with busy operands still give nothing.
		add_row(mk_op(FN_SPARE_LO, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX,
			TOL_MAX), 1'b1, mk_res(0, 0, 0, 0, 1'b0, 1'b0));
		add_row(mk_op(FN_SPARE_HI, WMIN, ONE, -1, 0, 0, 0, 0, ONE, WMIN, TOL_MAX), 1'b1,
			mk_res(0, 0, 0, 0, 1'b0, 1'b0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_rows[r])
			drive_item(corner_rows[r].op,
				corner_rows[r].typed ? corner_rows[r].want : compute_vector_op(corner_rows[r].op));

		// Random items. About one in ten uses an undefined code. Half of the compares
		// are built near their reference point with a small tolerance, so that both
		// outcomes of the flag are common.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if ($urandom_range(0, 9) == 0)
				op.func = $urandom_range(FN_SPARE_LO, FN_SPARE_HI);
			else
				op.func = $urandom_range(FN_ADD, FN_ZERO_TOL);
			op.ax    = pick_word();
			op.ay    = pick_word();
			op.az    = pick_word();
			op.aw    = pick_word();
			op.bx    = pick_word();
			op.by    = pick_word();
			op.bz    = pick_word();
			op.bw    = pick_word();
			op.scale = pick_word();
			case ($urandom_range(0, 4))
				0, 1:    op.tol = $urandom;
				2:       op.tol = $urandom_range(0, ONE);
				3:       op.tol = '0;
				default: op.tol = TOL_MAX;
			endcase
			near = $urandom_range(0, 1);
			if (op.func == FN_EQUAL_TOL && near) begin
				op.bx  = op.ax + jitter();
				op.by  = op.ay + jitter();
				op.bz  = op.az + jitter();
				op.bw  = op.aw + jitter();
				op.tol = $urandom_range(0, 300);
			end
			if (op.func == FN_ZERO_TOL && near) begin
				op.ax  = jitter();
				op.ay  = jitter();
				op.az  = jitter();
				op.aw  = ONE + jitter();
				op.tol = $urandom_range(0, 300);
			end
			drive_item(op, compute_vector_op(op));
		end
		s_tvalid <= 1'b0;

		// Drain, then give any stray extra result time to show up.
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** vector3_alu_top: PASSED **");
		else
			$display("** vector3_alu_top: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result sink: random stalls, stretches without stalls, and one long hold-off
	// while the source runs back to back, so the pipe fills and s_tready drops.
	// Each transfer is compared field by field with the oldest expectation.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int       stall;
		logic     bad;
		vec_res_t got;
		vec_res_t want;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (results_seen == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			results_seen++;
			got.rx   = m_tdata[0 * WORD_BITS +: WORD_BITS];
			got.ry   = m_tdata[1 * WORD_BITS +: WORD_BITS];
			got.rz   = m_tdata[2 * WORD_BITS +: WORD_BITS];
			got.rw   = m_tdata[3 * WORD_BITS +: WORD_BITS];
			got.flag = m_tuser[0];
			got.sat  = m_tuser[1];
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result %0d arrived with nothing expected: rx=%h ry=%h rz=%h rw=%h",
						results_seen, got.rx, got.ry, got.rz, got.rw);
			end else begin
				want = awaited_results.pop_front();
				bad  = (got.rx !== want.rx) || (got.ry !== want.ry) || (got.rz !== want.rz)
					|| (got.rw !== want.rw) || (got.flag !== want.flag)
					|| (got.sat !== want.sat);
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("result %0d mismatch: expected rx=%h ry=%h rz=%h rw=%h flag=%b sat=%b",
							results_seen, want.rx, want.ry, want.rz, want.rw, want.flag, want.sat);
						$display("                      got rx=%h ry=%h rz=%h rw=%h flag=%b sat=%b",
							got.rx, got.ry, got.rz, got.rw, got.flag, got.sat);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: a long run of cycles without any transfer on either side means
	// the block has hung or dropped a result.
	// ------------------------------------------------------------------
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("** vector3_alu_top: FAILED **");
		$finish;
	end

endmodule

// ===== vector3_alu_top.f =====
+incdir+rtl/core
rtl/core/v3alu_pkg.sv
rtl/core/v3alu_lane.sv
rtl/core/v3alu_merge.sv
rtl/core/vector3_alu_top.sv
verif/tb_vector3_alu_top.sv
